// File: hw/rtl/xcr_pkg.sv
// Shared types, byte codes and the CRC-16 byte step for the XMODEM-CRC receiver.
// No dependencies; every other file of the block imports this package.
package xcr_pkg;

   localparam int unsigned XCR_ADDR_WIDTH = 32;

   // opcodes of an input item
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // status codes of a result item
   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_BAD_BLK  = 3'd3;
   localparam logic [2:0] ST_BAD_CMP  = 3'd4;
   localparam logic [2:0] ST_BAD_CRC  = 3'd5;
   localparam logic [2:0] ST_NO_START = 3'd6;

   // register indexes
   localparam logic [1:0] REG_DEST_BASE     = 2'd0;
   localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd2;
   localparam logic [1:0] REG_MAX_POLLS     = 2'd3;

   // line bytes
   localparam logic [7:0] B_SOH  = 8'h01;
   localparam logic [7:0] B_STX  = 8'h02;
   localparam logic [7:0] B_EOT  = 8'h04;
   localparam logic [7:0] B_ACK  = 8'h06;
   localparam logic [7:0] B_NAK  = 8'h15;
   localparam logic [7:0] B_POLL = 8'h43;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [9:0] SHORT_BLOCK_LAST = 10'd127;
   localparam logic [9:0] LONG_BLOCK_LAST  = 10'd1023;
   localparam logic [31:0] SHORT_BLOCK_SIZE = 32'd128;
   localparam logic [31:0] LONG_BLOCK_SIZE  = 32'd1024;

   localparam logic [31:0] RST_DEST_BASE     = 32'd0;
   localparam logic [15:0] RST_SHORT_TIMEOUT = 16'd1500;
   localparam logic [15:0] RST_LONG_TIMEOUT  = 16'd5000;
   localparam logic [5:0]  RST_MAX_POLLS     = 6'd30;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } xcr_req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        wr_valid;
      logic [31:0] wr_addr;
      logic [7:0]  wr_data;
      logic        packet_ok;
      logic [2:0]  status;
      logic [31:0] byte_count;
   } xcr_rsp_type;

   typedef struct packed {
      logic [31:0] dest_base;
      logic [15:0] short_timeout_ticks;
      logic [15:0] long_timeout_ticks;
      logic [5:0]  max_polls;
   } xcr_cfg_type;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/xcr_csr.sv
// Configuration registers of the XMODEM-CRC receiver.
// Depends on xcr_pkg for the register indexes, reset values and xcr_cfg_type.
module xcr_csr
   import xcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [1:0]  wr_index,
   input  logic [31:0] wr_data,
   output xcr_cfg_type cfg
);

   xcr_cfg_type cfg_ff;
   xcr_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DEST_BASE:     cfg_in.dest_base = wr_data;
            REG_SHORT_TIMEOUT: cfg_in.short_timeout_ticks = wr_data[15:0];
            REG_LONG_TIMEOUT:  cfg_in.long_timeout_ticks = wr_data[15:0];
            REG_MAX_POLLS:     cfg_in.max_polls = wr_data[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_base           <= RST_DEST_BASE;
         cfg_ff.short_timeout_ticks <= RST_SHORT_TIMEOUT;
         cfg_ff.long_timeout_ticks  <= RST_LONG_TIMEOUT;
         cfg_ff.max_polls           <= RST_MAX_POLLS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/xcr_engine.sv
// Protocol state machine of the XMODEM-CRC receiver: one event per step,
// with the CRC byte update and the payload address. Depends on xcr_pkg.
module xcr_engine
   import xcr_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = XCR_ADDR_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_valid,
   input  xcr_req_type step_item,
   input  xcr_cfg_type cfg,
   output logic        res_valid,
   output xcr_rsp_type res_item
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_POLL = 3'd1,
      PH_BLK  = 3'd2,
      PH_CMP  = 3'd3,
      PH_DATA = 3'd4,
      PH_CRCH = 3'd5,
      PH_CRCL = 3'd6,
      PH_HEAD = 3'd7
   } phase_type;

   localparam logic [31:0] AddrMask =
      (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'(((64'd1 << ADDR_WIDTH) - 64'd1));

   phase_type   phase_ff, phase_in;
   logic [5:0]  poll_count_ff, poll_count_in;
   logic [15:0] wait_timer_ff, wait_timer_in;
   logic [7:0]  expected_block_ff, expected_block_in;
   logic        long_block_ff, long_block_in;
   logic [9:0]  byte_index_ff, byte_index_in;
   logic [15:0] crc_value_ff, crc_value_in;
   logic [31:0] write_offset_ff, write_offset_in;

   logic [15:0] timer_next;
   logic [15:0] limit;
   logic [9:0]  last_index;
   logic [31:0] block_size;
   logic [31:0] payload_addr;
   logic [7:0]  b;

   assign b          = step_item.rx_byte;
   assign timer_next = (wait_timer_ff == 16'hFFFF) ? wait_timer_ff : wait_timer_ff + 16'd1;
   assign limit      = (phase_ff == PH_HEAD) ? cfg.long_timeout_ticks : cfg.short_timeout_ticks;
   assign last_index = long_block_ff ? LONG_BLOCK_LAST : SHORT_BLOCK_LAST;
   assign block_size = long_block_ff ? LONG_BLOCK_SIZE : SHORT_BLOCK_SIZE;
   assign payload_addr =
      (cfg.dest_base + write_offset_ff + {22'd0, byte_index_ff}) & AddrMask;

   always_comb begin
      phase_in          = phase_ff;
      poll_count_in     = poll_count_ff;
      wait_timer_in     = wait_timer_ff;
      expected_block_in = expected_block_ff;
      long_block_in     = long_block_ff;
      byte_index_in     = byte_index_ff;
      crc_value_in      = crc_value_ff;
      write_offset_in   = write_offset_ff;
      res_valid         = 1'b0;
      res_item          = '0;

      if (step_valid) begin
         if (step_item.opcode == OP_START) begin
            phase_in          = PH_POLL;
            poll_count_in     = 6'd1;
            wait_timer_in     = '0;
            expected_block_in = 8'd1;
            long_block_in     = 1'b0;
            byte_index_in     = '0;
            crc_value_in      = '0;
            write_offset_in   = '0;
            res_valid         = 1'b1;
            res_item.tx_valid = 1'b1;
            res_item.tx_byte  = B_POLL;
         end else if (phase_ff != PH_IDLE && step_item.opcode == OP_TICK) begin
            wait_timer_in = timer_next;
            if (timer_next >= limit) begin
               wait_timer_in = '0;
               res_valid     = 1'b1;
               if (phase_ff == PH_POLL) begin
                  if (poll_count_ff >= cfg.max_polls) begin
                     phase_in        = PH_IDLE;
                     res_item.status = ST_NO_START;
                  end else begin
                     poll_count_in     = poll_count_ff + 6'd1;
                     res_item.tx_valid = 1'b1;
                     res_item.tx_byte  = B_POLL;
                  end
               end else begin
                  phase_in        = PH_IDLE;
                  res_item.status = ST_TIMEOUT;
               end
            end
         end else if (phase_ff != PH_IDLE && step_item.opcode == OP_BYTE) begin
            wait_timer_in = '0;
            case (phase_ff)
               PH_POLL, PH_HEAD: begin
                  if (b == B_SOH || b == B_STX) begin
                     long_block_in = (b == B_STX);
                     phase_in      = PH_BLK;
                  end else if (phase_ff == PH_HEAD) begin
                     if (b == B_EOT) begin
                        phase_in          = PH_IDLE;
                        res_valid         = 1'b1;
                        res_item.tx_valid = 1'b1;
                        res_item.tx_byte  = B_ACK;
                        res_item.status   = ST_COMPLETE;
                     end
                  end else begin
                     // stray byte while polling counts as a failed poll
                     res_valid = 1'b1;
                     if (poll_count_ff >= cfg.max_polls) begin
                        phase_in        = PH_IDLE;
                        res_item.status = ST_NO_START;
                     end else begin
                        poll_count_in     = poll_count_ff + 6'd1;
                        res_item.tx_valid = 1'b1;
                        res_item.tx_byte  = B_POLL;
                     end
                  end
               end
               PH_BLK: begin
                  if (b != expected_block_ff) begin
                     phase_in          = PH_IDLE;
                     res_valid         = 1'b1;
                     res_item.tx_valid = 1'b1;
                     res_item.tx_byte  = B_NAK;
                     res_item.status   = ST_BAD_BLK;
                  end else begin
                     phase_in = PH_CMP;
                  end
               end
               PH_CMP: begin
                  if (b != ~expected_block_ff) begin
                     phase_in        = PH_IDLE;
                     res_valid       = 1'b1;
                     res_item.status = ST_BAD_CMP;
                  end else begin
                     crc_value_in  = '0;
                     byte_index_in = '0;
                     phase_in      = PH_DATA;
                  end
               end
               PH_DATA: begin
                  crc_value_in  = crc_byte(crc_value_ff, b);
                  byte_index_in = byte_index_ff + 10'd1;
                  if (byte_index_ff == last_index) begin
                     phase_in = PH_CRCH;
                  end
                  res_valid         = 1'b1;
                  res_item.wr_valid = 1'b1;
                  res_item.wr_addr  = payload_addr;
                  res_item.wr_data  = b;
               end
               PH_CRCH: begin
                  if (b != crc_value_ff[15:8]) begin
                     phase_in        = PH_IDLE;
                     res_valid       = 1'b1;
                     res_item.status = ST_BAD_CRC;
                  end else begin
                     phase_in = PH_CRCL;
                  end
               end
               PH_CRCL: begin
                  res_valid = 1'b1;
                  if (b != crc_value_ff[7:0]) begin
                     phase_in        = PH_IDLE;
                     res_item.status = ST_BAD_CRC;
                  end else begin
                     write_offset_in    = write_offset_ff + block_size;
                     expected_block_in  = expected_block_ff + 8'd1;
                     byte_index_in      = '0;
                     phase_in           = PH_HEAD;
                     res_item.tx_valid  = 1'b1;
                     res_item.tx_byte   = B_ACK;
                     res_item.packet_ok = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
      res_item.byte_count = write_offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         poll_count_ff     <= '0;
         wait_timer_ff     <= '0;
         expected_block_ff <= 8'd1;
         long_block_ff     <= 1'b0;
         byte_index_ff     <= '0;
         crc_value_ff      <= '0;
         write_offset_ff   <= '0;
      end else begin
         phase_ff          <= phase_in;
         poll_count_ff     <= poll_count_in;
         wait_timer_ff     <= wait_timer_in;
         expected_block_ff <= expected_block_in;
         long_block_ff     <= long_block_in;
         byte_index_ff     <= byte_index_in;
         crc_value_ff      <= crc_value_in;
         write_offset_ff   <= write_offset_in;
      end
   end

`ifndef SYNTHESIS
   a_start_polls: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_item.opcode == OP_START |=> phase_ff == PH_POLL)
      else $error("start event did not enter polling");

   a_write_in_data: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_item.wr_valid |-> phase_ff == PH_DATA && !res_item.tx_valid)
      else $error("payload write outside of block data");

   a_ok_to_head: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_item.packet_ok |=> phase_ff == PH_HEAD && byte_index_ff == '0)
      else $error("confirmed block did not return to header wait");

   a_offset_on_ok: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_item.opcode != OP_START && !(res_valid && res_item.packet_ok)
      |=> $stable(write_offset_ff))
      else $error("byte count moved without a confirmed block");
`endif

endmodule

// File: hw/rtl/xmodem_crc_receiver.sv
// Top level of the XMODEM-CRC receiver: input register, protocol engine,
// result register and configuration port. Depends on xcr_pkg, xcr_csr, xcr_engine.
//
// Takes one event item per clock cycle (start, received byte, timer tick) while
// the result side is not stalled, and returns at most one result item per event.
// An event is held in the input register, then its result in the result
// register. The state machine and the CRC-16 byte step are combinational
// between those registers, so the sustained rate is one item per cycle while the result
// side is not stalled. Payload bytes leave as writes as they arrive;
// packet_ok on the ACK confirms the block, and after a failed block the
// consumer must drop that block's writes. The csr port is always ready;
// write it only while no event is in flight.
module xmodem_crc_receiver
   import xcr_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = XCR_ADDR_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  xcr_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output xcr_rsp_type rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   xcr_cfg_type cfg;

   logic        in_valid_ff, in_valid_in;
   xcr_req_type in_item_ff;
   logic        out_valid_ff, out_valid_in;
   xcr_rsp_type out_item_ff;

   logic        advance;
   logic        res_valid;
   xcr_rsp_type res_item;

   assign csr_ready = 1'b1;

   xcr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // item moves from input register through the engine when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   xcr_engine #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_item  (in_item_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res_item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for xmodem_crc_receiver: drives start, byte, tick and void items,
// keeps its own model of the XMODEM-CRC session and checks every reply item in order.
// Depends on xcr_pkg and the receiver RTL only.
module tb
   import xcr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_VOID = 2'd3;   // opcode the block does not decode
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int ITEMS_PER_MODE = 100;

   typedef enum logic [2:0] {
      SESS_IDLE, SESS_POLL, SESS_BLKNUM, SESS_BLKCMP,
      SESS_DATA, SESS_CRC_HI, SESS_CRC_LO, SESS_HEADER
   } sess_phase_type;

   // Session model: turns each accepted item into the reply it should cause
   class xfer_tracker;
      logic [31:0] dest_base;
      logic [15:0] short_to;
      logic [15:0] long_to;
      logic [5:0]  max_polls;

      sess_phase_type phase;
      logic [5:0]  polls;
      logic [15:0] timer;
      logic [7:0]  blk_num;
      logic        long_blk;
      logic [10:0] idx;
      logic [15:0] crc;
      logic [31:0] offset;

      xcr_rsp_type replies_due[$];
      int unsigned mismatches;

      function new();
         dest_base  = RST_DEST_BASE;
         short_to   = RST_SHORT_TIMEOUT;
         long_to    = RST_LONG_TIMEOUT;
         max_polls  = RST_MAX_POLLS;
         phase      = SESS_IDLE;
         polls      = '0;
         timer      = '0;
         blk_num    = 8'd1;
         long_blk   = 1'b0;
         idx        = '0;
         crc        = '0;
         offset     = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_DEST_BASE:     dest_base = value;
            REG_SHORT_TIMEOUT: short_to  = value[15:0];
            REG_LONG_TIMEOUT:  long_to   = value[15:0];
            REG_MAX_POLLS:     max_polls = value[5:0];
            default: ;
         endcase
      endfunction

      // serial form: one data bit into the feedback per shift
      static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
         logic [15:0] acc;
         logic        fb;
         acc = c;
         for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ d[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
               acc = acc ^ CRC_POLY;
            end
         end
         return acc;
      endfunction

      function void retry_poll(inout xcr_rsp_type r);
         timer = '0;
         if (polls >= max_polls) begin
            phase    = SESS_IDLE;
            r.status = ST_NO_START;
         end else begin
            polls      = polls + 6'd1;
            r.tx_valid = 1'b1;
            r.tx_byte  = B_POLL;
         end
      endfunction

      function bit open_block(logic [7:0] b);
         if (b == B_SOH || b == B_STX) begin
            long_blk = (b == B_STX);
            phase    = SESS_BLKNUM;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void take_event(xcr_req_type ev);
         xcr_rsp_type r;
         bit          reply;
         logic [15:0] limit;
         logic [31:0] blk_size;
         r        = '0;
         reply    = 1'b0;
         blk_size = long_blk ? LONG_BLOCK_SIZE : SHORT_BLOCK_SIZE;
         if (ev.opcode == OP_START) begin
            phase      = SESS_POLL;
            polls      = 6'd1;
            timer      = '0;
            blk_num    = 8'd1;
            long_blk   = 1'b0;
            idx        = '0;
            crc        = '0;
            offset     = '0;
            reply      = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte  = B_POLL;
         end else if (phase != SESS_IDLE && ev.opcode == OP_TICK) begin
            if (timer != 16'hFFFF) begin
               timer = timer + 16'd1;
            end
            limit = (phase == SESS_HEADER) ? long_to : short_to;
            if (timer >= limit) begin
               reply = 1'b1;
               if (phase == SESS_POLL) begin
                  retry_poll(r);
               end else begin
                  phase    = SESS_IDLE;
                  timer    = '0;
                  r.status = ST_TIMEOUT;
               end
            end
         end else if (phase != SESS_IDLE && ev.opcode == OP_BYTE) begin
            timer = '0;
            case (phase)
               SESS_POLL: begin
                  if (!open_block(ev.rx_byte)) begin
                     reply = 1'b1;
                     retry_poll(r);
                  end
               end
               SESS_HEADER: begin
                  if (!open_block(ev.rx_byte) && ev.rx_byte == B_EOT) begin
                     phase      = SESS_IDLE;
                     reply      = 1'b1;
                     r.tx_valid = 1'b1;
                     r.tx_byte  = B_ACK;
                     r.status   = ST_COMPLETE;
                  end
               end
               SESS_BLKNUM: begin
                  if (ev.rx_byte != blk_num) begin
                     phase      = SESS_IDLE;
                     reply      = 1'b1;
                     r.tx_valid = 1'b1;
                     r.tx_byte  = B_NAK;
                     r.status   = ST_BAD_BLK;
                  end else begin
                     phase = SESS_BLKCMP;
                  end
               end
               SESS_BLKCMP: begin
                  if (ev.rx_byte != ~blk_num) begin
                     phase    = SESS_IDLE;
                     reply    = 1'b1;
                     r.status = ST_BAD_CMP;
                  end else begin
                     crc   = '0;
                     idx   = '0;
                     phase = SESS_DATA;
                  end
               end
               SESS_DATA: begin
                  crc        = crc16_step(crc, ev.rx_byte);
                  reply      = 1'b1;
                  r.wr_valid = 1'b1;
                  r.wr_addr  = dest_base + offset + {21'd0, idx};
                  r.wr_data  = ev.rx_byte;
                  idx        = idx + 11'd1;
                  if ({21'd0, idx} >= blk_size) begin
                     phase = SESS_CRC_HI;
                  end
               end
               SESS_CRC_HI, SESS_CRC_LO: begin
                  if (ev.rx_byte != ((phase == SESS_CRC_HI) ? crc[15:8] : crc[7:0])) begin
                     phase    = SESS_IDLE;
                     reply    = 1'b1;
                     r.status = ST_BAD_CRC;
                  end else if (phase == SESS_CRC_HI) begin
                     phase = SESS_CRC_LO;
                  end else begin
                     offset      = offset + blk_size;
                     blk_num     = blk_num + 8'd1;
                     idx         = '0;
                     phase       = SESS_HEADER;
                     reply       = 1'b1;
                     r.tx_valid  = 1'b1;
                     r.tx_byte   = B_ACK;
                     r.packet_ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (reply) begin
            r.byte_count = offset;
            replies_due.push_back(r);
         end
      endfunction

      function void diff(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(xcr_rsp_type got);
         xcr_rsp_type want;
         if (replies_due.size() == 0) begin
            $error("reply item with none expected: %p", got);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         diff("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
         diff("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
         diff("wr_valid", 32'(want.wr_valid), 32'(got.wr_valid));
         diff("wr_addr", want.wr_addr, got.wr_addr);
         diff("wr_data", 32'(want.wr_data), 32'(got.wr_data));
         diff("packet_ok", 32'(want.packet_ok), 32'(got.packet_ok));
         diff("status", 32'(want.status), 32'(got.status));
         diff("byte_count", want.byte_count, got.byte_count);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   xcr_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   xcr_rsp_type rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_DEST_BASE;
   logic [31:0] csr_data = '0;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;
   int unsigned events_sent = 0;
   xfer_tracker tracker;

   xmodem_crc_receiver dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb NOT OK");
      $finish;
   end

   // reply side: check accepted items, random back-pressure, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         tracker.check_reply(rsp_item);
      end
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_event(logic [1:0] op, logic [7:0] data);
      xcr_req_type ev;
      ev.opcode  = op;
      ev.rx_byte = data;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= ev;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      tracker.take_event(ev);
      events_sent++;
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      tracker.set_reg(index, value);
   endtask

   task automatic configure(logic [31:0] base, logic [15:0] short_ticks,
                            logic [15:0] long_ticks, logic [5:0] poll_max);
      write_reg(REG_DEST_BASE, base);
      write_reg(REG_SHORT_TIMEOUT, {16'd0, short_ticks});
      write_reg(REG_LONG_TIMEOUT, {16'd0, long_ticks});
      write_reg(REG_MAX_POLLS, {26'd0, poll_max});
      csr_valid <= 1'b0;
   endtask

   // wait out every expected reply, then the pipeline's own latency
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == B_SOH || b == B_STX || b == B_EOT);
      return b;
   endfunction

   // ticks that stay under the given timeout
   task automatic idle_ticks(logic [15:0] limit);
      int unsigned n;
      n = (limit > 16'd1) ? $urandom_range((limit > 16'd4) ? 3 : limit - 1) : 0;
      repeat (n) send_event(OP_TICK, 8'($urandom));
   endtask

   task automatic expire();
      while (tracker.phase != SESS_IDLE) send_event(OP_TICK, 8'($urandom));
   endtask

   task automatic line_noise();
      repeat ($urandom_range(4)) begin
         case ($urandom_range(2))
            0: send_event(OP_BYTE, 8'($urandom));
            1: send_event(OP_TICK, 8'($urandom));
            default: send_event(OP_VOID, 8'($urandom));
         endcase
      end
   endtask

   // one short block, clean or with one fault
   task automatic send_block();
      int unsigned fault;
      logic [7:0]  num;
      logic [15:0] corrupt;
      logic [15:0] crc_line;
      fault = $urandom_range(11);
      num   = tracker.blk_num;
      send_event(OP_BYTE, B_SOH);
      send_event(OP_BYTE, (fault == 0) ? num ^ 8'($urandom_range(1, 255)) : num);
      if (tracker.phase != SESS_BLKCMP) return;
      send_event(OP_BYTE, (fault == 1) ? ~num ^ 8'($urandom_range(1, 255)) : ~num);
      while (tracker.phase == SESS_DATA) begin
         if (fault == 3 && tracker.short_to <= 16'd64 && $urandom_range(31) == 0) begin
            expire();
            return;
         end
         // abandon mid-block; the next session start begins a new transfer from block 1
         if (fault == 4 && $urandom_range(63) == 0) return;
         if ($urandom_range(15) == 0) idle_ticks(tracker.short_to);
         if ($urandom_range(63) == 0) send_event(OP_VOID, 8'($urandom));
         send_event(OP_BYTE, 8'($urandom));
      end
      corrupt  = (fault == 2) ? 16'($urandom_range(1, 65535)) : 16'd0;
      crc_line = tracker.crc ^ corrupt;
      send_event(OP_BYTE, crc_line[15:8]);
      if (tracker.phase == SESS_CRC_LO) send_event(OP_BYTE, crc_line[7:0]);
   endtask

   task automatic run_session();
      int unsigned blocks;
      send_event(OP_START, 8'($urandom));
      repeat ($urandom_range(3)) begin
         if (tracker.phase != SESS_POLL) return;
         if ($urandom_range(1) == 1 && tracker.short_to <= 16'd64) begin
            // let this poll time out
            do send_event(OP_TICK, 8'($urandom)); while (tracker.timer != 0);
         end else begin
            send_event(OP_BYTE, stray_byte());
         end
      end
      if (tracker.phase != SESS_POLL) return;
      blocks = $urandom_range(1, 2);
      for (int k = 0; k < blocks; k++) begin
         send_block();
         if (tracker.phase != SESS_HEADER) return;
         case ($urandom_range(5))
            0: send_event(OP_BYTE, stray_byte());
            1: idle_ticks(tracker.long_to);
            2: begin
               if (tracker.long_to <= 16'd64) begin
                  expire();
                  return;
               end
            end
            default: ;
         endcase
      end
      if ($urandom_range(3) != 0) send_event(OP_BYTE, B_EOT);
   endtask

   initial begin
      int unsigned mark;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(32'h0000_0000, 16'd2, 16'd1, 6'd2);
      send_event(OP_BYTE, 8'hFF);       // idle: ignored
      send_event(OP_TICK, 8'h00);
      send_event(OP_VOID, 8'h00);
      send_event(OP_START, 8'h00);
      send_event(OP_VOID, 8'hAA);       // ignored while polling
      send_event(OP_BYTE, 8'h55);       // garbage counts as a failed poll
      send_event(OP_TICK, 8'h00);
      send_event(OP_TICK, 8'h00);       // poll budget used up
      send_event(OP_START, 8'h00);
      send_event(OP_BYTE, B_SOH);
      send_event(OP_BYTE, 8'h02);       // wrong block number -> NAK
      send_event(OP_START, 8'h00);
      send_event(OP_BYTE, B_STX);
      send_event(OP_BYTE, 8'h01);
      send_event(OP_BYTE, 8'h00);       // wrong complement
      send_event(OP_START, 8'h00);
      send_event(OP_BYTE, B_SOH);
      send_event(OP_BYTE, 8'h01);
      send_event(OP_START, 8'hFF);      // restart inside a block
      send_event(OP_BYTE, B_STX);
      send_event(OP_BYTE, 8'h01);
      send_event(OP_BYTE, 8'hFE);
      send_event(OP_BYTE, 8'hFF);
      send_event(OP_TICK, 8'h00);
      send_event(OP_TICK, 8'h00);       // timeout inside the block
      settle();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 7;
               rsp_idle_pct = 67;
               configure(32'hFFFF_FFA0, 16'hFFFF, 16'hFFFF, 6'd63);
            end
            1: begin
               req_idle_pct = 67;
               rsp_idle_pct = 7;
               configure($urandom, 16'd0, 16'd1, 6'd1);
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               configure($urandom, 16'd7, 16'd12, 6'd5);
            end
         endcase
         mark = events_sent;
         if (mode == 2) begin
            hold_req <= 1'b1;
         end
         while (events_sent - mark < ITEMS_PER_MODE) begin
            line_noise();
            run_session();
         end
         settle();
      end

      if (tracker.mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// File: xmodem_crc_receiver.f
hw/rtl/xcr_pkg.sv
hw/rtl/xcr_csr.sv
hw/rtl/xcr_engine.sv
hw/rtl/xmodem_crc_receiver.sv
tb/tb.sv
